// ----- rtl/core/pts_pkg.sv -----
// Package for the periodic timer scheduler: payload structs, codes,
// sequencer types and shared constants. No dependencies.
`default_nettype none
package pts_pkg;

    localparam int SLOTS_DEF = 16;
    localparam logic [31:0] MIN_WAIT = 32'd5;
    localparam logic [31:0] NO_WAIT  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [1:0] KIND_EXPIRED = 2'd0;
    localparam logic [1:0] KIND_WAIT    = 2'd1;
    localparam logic [1:0] KIND_REFUSED = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  timer_id;
        logic [15:0] period_ms;
        logic [31:0] now_ms;
        logic [31:0] late_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] elapsed_ms;
        logic [31:0] wait_ms;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE,
        ST_EMIT_EXP,
        ST_WAIT_CALC,
        ST_EMIT_WAIT,
        ST_EMIT_REF
    } t_state;

    typedef enum logic [2:0] {
        PH_FILE1,
        PH_EXP_ALL,
        PH_EXP_NOW,
        PH_FILE2,
        PH_NEAR_CUR,
        PH_NEAR_OTH
    } t_phase;

    // Compare results of the shared deadline unit
    typedef struct packed {
        logic [31:0] deadline;
        logic        lt_last;
        logic        le_now;
        logic        lt_best;
    } t_dl_res;

endpackage
`default_nettype wire

// ----- rtl/core/pts_dl_unit.sv -----
// Shared deadline unit: forms start time plus period and compares it
// against the previous tick time, the current time and the running best.
// Depends on pts_pkg.
`default_nettype none
module pts_dl_unit (
    input  wire logic [31:0]      i_start,
    input  wire logic [15:0]      i_period,
    input  wire logic [31:0]      i_last_tick,
    input  wire logic [31:0]      i_now,
    input  wire logic [31:0]      i_best,
    output pts_pkg::t_dl_res      o_res
);
    import pts_pkg::*;

    logic [31:0] dl;

    // Deadline wraps modulo 2^32
    assign dl = i_start + {16'd0, i_period};

    always_comb begin
        o_res.deadline = dl;
        o_res.lt_last  = dl < i_last_tick;
        o_res.le_now   = dl <= i_now;
        o_res.lt_best  = dl < i_best;
    end

endmodule
`default_nettype wire

// ----- rtl/core/periodic_timer_scheduler_top.sv -----
// Top level of the periodic timer scheduler: slot table, sequencer and
// output register. Depends on pts_pkg and pts_dl_unit.
//
//  channel | direction | handshake             | payload
//  input   | in        | i_in_valid/o_in_stall | i_in_data (t_in_item)
//  output  | out       | o_out_valid/i_out_stall | o_out_data (t_out_item)
//
// Start and stop are done in the idle state; a refused start emits once the output register is free.
// A tick scans the table one slot per cycle, pass by pass: a filing pass,
// one pass per expired slot plus one (two after a wrap), a second filing pass and one
// or two nearest passes; with E expiries a tick makes E + P passes, P = 4..6.
// All scans share one deadline adder and compare unit.
// Reset clears armed, pending, epoch and last tick time; no clearing pass.
// Output stalls hold the sequencer only where it has a result to deliver.
`default_nettype none
module periodic_timer_scheduler_top #(
    parameter int SLOTS = pts_pkg::SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire pts_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output pts_pkg::t_out_item      o_out_data
);
    import pts_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Slot table
    logic [SLOTS-1:0] r_armed;
    logic [SLOTS-1:0] r_pend;
    logic [SLOTS-1:0] r_ep;
    logic [15:0]      r_per [SLOTS];
    logic [31:0]      r_st  [SLOTS];
    logic             r_cur;
    logic [31:0]      r_last_tick;

    // Sequencer
    t_state           r_state, n_state;
    t_phase           r_phase;
    logic [IW-1:0]    r_idx;
    logic             r_found;
    logic [31:0]      r_best_d;
    logic [IW-1:0]    r_best_i;
    logic [31:0]      r_best_el;
    logic [31:0]      r_now;
    logic [31:0]      r_late;
    logic             r_wrapped;
    logic [31:0]      r_wait;
    logic [3:0]       r_ref_slot;

    // Output register
    logic             r_out_valid;
    t_out_item        r_out;

    logic             in_acc;
    logic             out_free;
    logic             out_load;
    logic             id_ok;
    logic [IW-1:0]    id_idx;
    logic             scan_last;
    logic [31:0]      rd_st;
    logic [15:0]      rd_per;
    t_dl_res          dl;
    logic             filed;
    logic             cand;
    logic [31:0]      dt;
    logic [31:0]      dt_late;
    logic [31:0]      wait_val;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = out_free && (r_state == ST_EMIT_EXP || r_state == ST_EMIT_WAIT
                                   || r_state == ST_EMIT_REF);
    assign id_ok    = 32'(i_in_data.timer_id) < SLOTS;
    assign id_idx   = IW'(i_in_data.timer_id);
    assign scan_last = r_idx == IW'(SLOTS - 1);
    assign rd_st    = r_st[r_idx];
    assign rd_per   = r_per[r_idx];

    pts_dl_unit u_dl (
        .i_start     (rd_st),
        .i_period    (rd_per),
        .i_last_tick (r_last_tick),
        .i_now       (r_now),
        .i_best      (r_best_d),
        .o_res       (dl)
    );

    // Select which slots take part in the current scan
    always_comb begin
        filed = r_armed[r_idx] && !r_pend[r_idx];
        unique case (r_phase)
            PH_EXP_ALL:  cand = filed && (r_ep[r_idx] == r_cur);
            PH_EXP_NOW:  cand = filed && (r_ep[r_idx] == r_cur) && dl.le_now;
            PH_NEAR_CUR: cand = filed && (r_ep[r_idx] == r_cur);
            PH_NEAR_OTH: cand = filed && (r_ep[r_idx] != r_cur);
            default:     cand = 1'b0;
        endcase
    end

    // Wait until the nearest deadline, less lateness: zero if lateness covers it, else at least MIN_WAIT
    always_comb begin
        dt      = r_best_d - r_now;
        dt_late = dt - r_late;
        if (r_late >= dt) begin
            wait_val = '0;
        end else if (dt_late < MIN_WAIT) begin
            wait_val = MIN_WAIT;
        end else begin
            wait_val = dt_late;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_data.operation == OP_TICK) begin
                    n_state = ST_SCAN;
                end else if (in_acc && i_in_data.operation == OP_START && id_ok
                             && r_armed[id_idx]) begin
                    n_state = ST_EMIT_REF;
                end
            end
            ST_SCAN: begin
                if (scan_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                priority case (r_phase)
                    PH_EXP_ALL, PH_EXP_NOW: n_state = r_found ? ST_EMIT_EXP : ST_SCAN;
                    PH_NEAR_CUR:            n_state = r_found ? ST_WAIT_CALC : ST_SCAN;
                    PH_NEAR_OTH:            n_state = r_found ? ST_WAIT_CALC : ST_EMIT_WAIT;
                    default:                n_state = ST_SCAN;
                endcase
            end
            ST_EMIT_EXP: begin
                if (out_free) n_state = ST_SCAN;
            end
            ST_WAIT_CALC: n_state = ST_EMIT_WAIT;
            ST_EMIT_WAIT: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_EMIT_REF: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_in_stall  = r_state != ST_IDLE;
        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_armed     <= '0;
            r_pend      <= '0;
            r_ep        <= '0;
            r_cur       <= 1'b0;
            r_last_tick <= '0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_FILE1;
            r_idx       <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;

            // Load a new result or hold the one not yet taken
            r_out_valid <= out_load || (r_out_valid && i_out_stall);

            unique case (r_state)
                ST_IDLE: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_phase <= PH_FILE1;
                    if (in_acc) begin
                        r_now      <= i_in_data.now_ms;
                        r_late     <= i_in_data.late_ms;
                        r_wrapped  <= i_in_data.now_ms < r_last_tick;
                        r_ref_slot <= i_in_data.timer_id;
                        if (i_in_data.operation == OP_START && id_ok
                            && !r_armed[id_idx]) begin
                            r_armed[id_idx] <= 1'b1;
                            r_pend[id_idx]  <= 1'b1;
                            r_per[id_idx]   <= i_in_data.period_ms;
                            r_st[id_idx]    <= i_in_data.now_ms;
                        end else if (i_in_data.operation == OP_STOP && id_ok) begin
                            r_armed[id_idx] <= 1'b0;
                            r_pend[id_idx]  <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    // File pending slots into an epoch
                    if ((r_phase == PH_FILE1 || r_phase == PH_FILE2)
                        && r_armed[r_idx] && r_pend[r_idx]) begin
                        r_ep[r_idx]   <= dl.lt_last ? !r_cur : r_cur;
                        r_pend[r_idx] <= 1'b0;
                    end
                    // Track the earliest candidate, lower index wins ties
                    if (cand && (!r_found || dl.lt_best)) begin
                        r_found   <= 1'b1;
                        r_best_d  <= dl.deadline;
                        r_best_i  <= r_idx;
                        r_best_el <= r_now - rd_st;
                    end
                    if (!scan_last) r_idx <= r_idx + 1'b1;
                end
                ST_DONE: begin
                    r_idx <= '0;
                    priority case (r_phase)
                        PH_FILE1: begin
                            r_last_tick <= r_now;
                            r_found     <= 1'b0;
                            r_phase     <= r_wrapped ? PH_EXP_ALL : PH_EXP_NOW;
                        end
                        PH_EXP_ALL: begin
                            if (!r_found) begin
                                r_cur   <= !r_cur;
                                r_phase <= PH_EXP_NOW;
                            end
                        end
                        PH_EXP_NOW: begin
                            if (!r_found) r_phase <= PH_FILE2;
                        end
                        PH_FILE2: begin
                            r_found <= 1'b0;
                            r_phase <= PH_NEAR_CUR;
                        end
                        PH_NEAR_CUR: begin
                            if (!r_found) r_phase <= PH_NEAR_OTH;
                        end
                        default: begin
                            if (!r_found) r_wait <= NO_WAIT;
                        end
                    endcase
                end
                ST_EMIT_EXP: begin
                    // Emit the expiry and re-arm the slot from the tick time
                    if (out_free) begin
                        r_out.kind        <= KIND_EXPIRED;
                        r_out.slot        <= 4'(r_best_i);
                        r_out.elapsed_ms  <= r_best_el;
                        r_out.wait_ms     <= '0;
                        r_out.last        <= 1'b0;
                        r_st[r_best_i]    <= r_now;
                        r_pend[r_best_i]  <= 1'b1;
                        r_found           <= 1'b0;
                        r_idx             <= '0;
                    end
                end
                ST_WAIT_CALC: r_wait <= wait_val;
                ST_EMIT_WAIT: begin
                    if (out_free) begin
                        r_out.kind       <= KIND_WAIT;
                        r_out.slot       <= '0;
                        r_out.elapsed_ms <= '0;
                        r_out.wait_ms    <= r_wait;
                        r_out.last       <= 1'b1;
                    end
                end
                ST_EMIT_REF: begin
                    if (out_free) begin
                        r_out.kind       <= KIND_REFUSED;
                        r_out.slot       <= r_ref_slot;
                        r_out.elapsed_ms <= '0;
                        r_out.wait_ms    <= '0;
                        r_out.last       <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // An expiry is only emitted after a scan found a slot
    a_exp_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT_EXP |-> r_found)
        else $error("expiry emit without a found slot");

    // A pending slot is always armed
    a_pend_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & ~r_armed) == '0)
        else $error("pending slot not armed");

    // Wait reports and refusals close a transaction, expiries never do
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.last == (r_out.kind != KIND_EXPIRED)))
        else $error("last flag does not match result kind");

    // Input is stalled while a tick scans or emits expiries
    a_idle_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_EMIT_EXP) |-> o_in_stall)
        else $error("input open during tick");

endmodule
`default_nettype wire

// ----- tb/sv/pts_checker.sv -----
// Checker for the periodic timer scheduler: watches both channels, predicts
// expiries, refusals and wait reports, and compares them. Depends on pts_pkg.
`default_nettype none
module pts_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire pts_pkg::t_in_item  i_in_data,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire pts_pkg::t_out_item i_out_data,
    output int                      o_fail_count,
    output int                      o_expected_count,
    output int                      o_result_count
);
    import pts_pkg::*;

    localparam int NSLOT = 16;

    logic        slot_armed   [NSLOT];
    logic        slot_pending [NSLOT];
    logic [15:0] slot_period  [NSLOT];
    logic [31:0] slot_start   [NSLOT];
    logic        slot_epoch   [NSLOT];
    logic        cur_epoch;
    logic [31:0] prev_tick;

    t_out_item expected_results [$];

    function automatic logic [31:0] due(int i);
        return slot_start[i] + {16'd0, slot_period[i]};
    endfunction

    // File pending slots into the current or the next epoch
    function automatic void file_slots();
        for (int i = 0; i < NSLOT; i++) begin
            if (slot_armed[i] && slot_pending[i]) begin
                slot_epoch[i] = (due(i) < prev_tick) ? ~cur_epoch : cur_epoch;
                slot_pending[i] = 1'b0;
            end
        end
    endfunction

    function automatic void push_result(logic [1:0] k, logic [3:0] s,
                                        logic [31:0] el, logic [31:0] w, logic l);
        t_out_item r;
        r.kind = k;
        r.slot = s;
        r.elapsed_ms = el;
        r.wait_ms = w;
        r.last = l;
        expected_results = {expected_results, r};
    endfunction

    // Expire filed slots of the current epoch in deadline order
    function automatic void expire_slots(logic bounded, logic [31:0] now);
        int best;
        logic [31:0] best_d;
        logic [31:0] d;
        forever begin
            best = -1;
            best_d = '0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!slot_armed[i] || slot_pending[i] || slot_epoch[i] != cur_epoch)
                    continue;
                d = due(i);
                if (bounded && d > now) continue;
                if (best < 0 || d < best_d) begin
                    best = i;
                    best_d = d;
                end
            end
            if (best < 0) return;
            push_result(KIND_EXPIRED, 4'(best), now - slot_start[best], '0, 1'b0);
            slot_start[best] = now;
            slot_pending[best] = 1'b1;
        end
    endfunction

    function automatic logic nearest_due(logic ep, inout logic [31:0] target);
        logic found;
        found = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            if (slot_armed[i] && !slot_pending[i] && slot_epoch[i] == ep) begin
                if (!found || due(i) < target) target = due(i);
                found = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic void predict_schedule(t_in_item it);
        logic [31:0] target;
        logic [31:0] dt;
        logic wrapped;
        case (t_op'(it.operation))
            OP_START: begin
                if (slot_armed[it.timer_id]) begin
                    push_result(KIND_REFUSED, it.timer_id, '0, '0, 1'b1);
                end else begin
                    slot_armed[it.timer_id] = 1'b1;
                    slot_pending[it.timer_id] = 1'b1;
                    slot_period[it.timer_id] = it.period_ms;
                    slot_start[it.timer_id] = it.now_ms;
                end
            end
            OP_STOP: begin
                slot_armed[it.timer_id] = 1'b0;
                slot_pending[it.timer_id] = 1'b0;
            end
            OP_TICK: begin
                target = '0;
                wrapped = it.now_ms < prev_tick;
                file_slots();
                prev_tick = it.now_ms;
                if (wrapped) begin
                    expire_slots(1'b0, it.now_ms);
                    cur_epoch = ~cur_epoch;
                end
                expire_slots(1'b1, it.now_ms);
                file_slots();
                if (!nearest_due(cur_epoch, target) && !nearest_due(~cur_epoch, target)) begin
                    push_result(KIND_WAIT, '0, '0, NO_WAIT, 1'b1);
                end else begin
                    dt = target - it.now_ms;
                    if (it.late_ms >= dt) begin
                        dt = '0;
                    end else begin
                        dt = dt - it.late_ms;
                        if (dt < MIN_WAIT) dt = MIN_WAIT;
                    end
                    push_result(KIND_WAIT, '0, '0, dt, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    // Predict on accepted inputs, compare accepted results
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                slot_armed[i] = 1'b0;
                slot_pending[i] = 1'b0;
                slot_period[i] = '0;
                slot_start[i] = '0;
                slot_epoch[i] = 1'b0;
            end
            cur_epoch = 1'b0;
            prev_tick = '0;
            o_fail_count <= 0;
            o_expected_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_result_count <= o_result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    if (exp_r !== i_out_data) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_r, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_schedule(i_in_data);
            o_expected_count <= expected_results.size();
        end
    end
endmodule
`default_nettype wire

// ----- tb/sv/tb_periodic_timer_scheduler_top.sv -----
// Testbench top for the periodic timer scheduler: clock, reset, stimulus,
// idling and verdict. Depends on pts_pkg, pts_checker and the block.
`default_nettype none
module tb_periodic_timer_scheduler_top;
    import pts_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        expected_count;
    int        result_count;
    int        idle_cycles = 0;
    logic      quiet_stretch = 1'b0;
    logic [31:0] clock_ms = 32'd100;
    int        sent = 0;

    always #4 i_clk = ~i_clk;

    periodic_timer_scheduler_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    pts_checker checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_expected_count(expected_count),
        .o_result_count(result_count)
    );

    // Stall the result channel at random, except in the quiet stretch
    always_ff @(posedge i_clk) begin
        out_stall <= !quiet_stretch && ($urandom_range(99) < 8);
    end

    // Count cycles without any transaction
    always_ff @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    // Present one transaction, idling at random beforehand; valid stays up
    // until the next call or the drain replaces it
    task automatic send_item(logic [1:0] op, logic [3:0] id, logic [15:0] per,
                             logic [31:0] now, logic [31:0] late);
        t_in_item it;
        while (!quiet_stretch && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        it.operation = op;
        it.timer_id = id;
        it.period_ms = per;
        it.now_ms = now;
        it.late_ms = late;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_count != 0 && guard < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (400) @(posedge i_clk);
    endtask

    // Mostly in-order time, bursts of starts and stops, occasional wraps
    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_item(OP_START, 4'($urandom), ($urandom_range(3) == 0) ? 16'($urandom)
                      : 16'($urandom_range(60)), clock_ms, $urandom);
        end else if (pick < 42) begin
            send_item(OP_STOP, 4'($urandom), 16'($urandom), $urandom, $urandom);
        end else if (pick < 46) begin
            send_item(OP_NONE, 4'($urandom), 16'($urandom), $urandom, $urandom);
        end else begin
            case ($urandom_range(9))
                0: clock_ms = $urandom;
                1: clock_ms = 32'hFFFF_FFFF - $urandom_range(40);
                default: clock_ms = clock_ms + $urandom_range(30);
            endcase
            send_item(OP_TICK, 4'($urandom), 16'($urandom), clock_ms,
                      ($urandom_range(1) == 0) ? 32'($urandom_range(10)) : $urandom);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty tick, extremes, refusal, stop, ties and a wrap
        send_item(OP_TICK, 4'd0, 16'd0, 32'd0, 32'd0);
        send_item(OP_START, 4'd0, 16'd0, 32'd0, 32'd0);
        send_item(OP_START, 4'd15, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_START, 4'd15, 16'd7, 32'd0, 32'd0);
        send_item(OP_START, 4'd3, 16'd10, 32'd0, 32'd0);
        send_item(OP_START, 4'd4, 16'd10, 32'd0, 32'd0);
        send_item(OP_TICK, 4'd0, 16'd0, 32'd8, 32'd0);
        send_item(OP_TICK, 4'd0, 16'd0, 32'd10, 32'd1);
        send_item(OP_TICK, 4'd0, 16'd0, 32'd12, 32'd4);
        send_item(OP_STOP, 4'd7, 16'd0, 32'd0, 32'd0);
        send_item(OP_STOP, 4'd0, 16'd0, 32'd0, 32'd0);
        send_item(OP_TICK, 4'd0, 16'd0, 32'hFFFF_FFF0, 32'd0);
        send_item(OP_TICK, 4'd0, 16'd0, 32'd5, 32'hFFFF_FFFF);
        send_item(OP_NONE, 4'd9, 16'd1, 32'd1, 32'd1);
        send_item(OP_STOP, 4'd15, 16'd0, 32'd0, 32'd0);
        send_item(OP_STOP, 4'd3, 16'd0, 32'd0, 32'd0);
        send_item(OP_STOP, 4'd4, 16'd0, 32'd0, 32'd0);
        send_item(OP_TICK, 4'd0, 16'd0, 32'd6, 32'd0);
        drain();

        // Random, with a quiet stretch in the middle
        for (int n = 0; n < 152; n++) begin
            quiet_stretch <= (n >= 50 && n < 90);
            random_item();
        end
        quiet_stretch <= 1'b0;
        drain();

        $display("sent %0d items, checked %0d results incl. wraps and refusals",
                 sent, result_count);
        if (fail_count == 0 && expected_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/pts_pkg.sv
rtl/core/pts_dl_unit.sv
rtl/core/periodic_timer_scheduler_top.sv
tb/sv/pts_checker.sv
tb/sv/tb_periodic_timer_scheduler_top.sv
